// ===== rtl/plir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plir_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ID_W    = 32;
    localparam int RANK_W  = 32;
    localparam int PRANK_W = 16;
    localparam int ACT_W   = 3;
    localparam int KIND_W  = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INTERSECT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_COMMIT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SCAN_RD  = 11'b000_0000_0010,
        ST_SCAN_EV  = 11'b000_0000_0100,
        ST_SHIFT_RD = 11'b000_0000_1000,
        ST_SHIFT_WR = 11'b000_0001_0000,
        ST_CMT_RD   = 11'b000_0010_0000,
        ST_CMT_EV   = 11'b000_0100_0000,
        ST_SORT_RD  = 11'b000_1000_0000,
        ST_SORT_EV  = 11'b001_0000_0000,
        ST_EMIT     = 11'b010_0000_0000,
        ST_DECIDE   = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/posting_list_intersect_rank_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ranked posting-list table: up to TABLE_DEPTH (id, rank) entries kept in
// ascending id order in a single-port-write, registered-read memory, walked by
// one sequencer with one compare/add unit. Every memory visit sets the address,
// then uses the registered read data. Add and intersect scan from the bottom
// to find the place p, and an insert then shifts the tail up from the top;
// commit walks the whole table once; clear and unused codes go straight to
// their result word; a read-out makes count selection passes over the table,
// one entry word per pass.
// The block takes no new word until the current one has handed its last
// result word to the output register, which holds it until it is taken.
module posting_list_intersect_rank_top
    import plir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // doc_id [31:0], posting_rank [47:32]
    input  wire logic [2:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // out_doc_id [31:0], out_rank [63:32],
                                        // overflow [64], zero fill [71:65]
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);

    // entry memory: rank in upper half, id in lower half
    logic [RANK_W+ID_W-1:0] mem [TABLE_DEPTH];
    logic [RANK_W+ID_W-1:0] rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [RANK_W+ID_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    state_t state_reg, state_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic [PRANK_W-1:0] prank_reg, prank_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [TABLE_DEPTH-1:0] mark_reg, mark_next;

    // selection state for read-out
    logic               first_reg, first_next;
    logic [RANK_W-1:0]  prev_rank_reg, prev_rank_next;
    logic [ADDR_W-1:0]  prev_idx_reg, prev_idx_next;
    logic               best_vld_reg, best_vld_next;
    logic [RANK_W-1:0]  best_rank_reg, best_rank_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;

    // pending result word
    logic [KIND_W-1:0]  pkind_reg, pkind_next;
    logic [ID_W-1:0]    pid_reg, pid_next;
    logic [RANK_W-1:0]  prk_reg, prk_next;
    logic               povf_reg, povf_next;
    logic               plast_reg, plast_next;
    logic               pmore_reg, pmore_next;

    // output register
    logic               ovld_reg, ovld_next;
    logic [KIND_W-1:0]  okind_reg, okind_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [RANK_W-1:0]  ork_reg, ork_next;
    logic               oovf_reg, oovf_next;
    logic               olast_reg, olast_next;

    // shared arithmetic
    logic [ID_W-1:0]    rd_id;
    logic [RANK_W-1:0]  rd_rank;
    logic [RANK_W:0]    sum_wide;
    logic [RANK_W-1:0]  sum_sat;
    logic [CNT_W-1:0]   jm1;
    logic [ADDR_W-1:0]  cur_idx;
    logic               eligible;
    logic               better;

    assign rd_id    = rdata_reg[ID_W-1:0];
    assign rd_rank  = rdata_reg[RANK_W+ID_W-1:ID_W];
    assign sum_wide = {1'b0, rd_rank} + {{(RANK_W+1-PRANK_W){1'b0}}, prank_reg};
    assign sum_sat  = sum_wide[RANK_W] ? {RANK_W{1'b1}} : sum_wide[RANK_W-1:0];
    assign jm1      = j_reg - CNT_W'(1);
    assign cur_idx  = idx_reg[ADDR_W-1:0];
    assign eligible = first_reg || (rd_rank < prev_rank_reg)
                      || ((rd_rank == prev_rank_reg) && (cur_idx > prev_idx_reg));
    assign better   = !best_vld_reg || (rd_rank > best_rank_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ovld_reg;
    assign m_tdata   = {7'd0, oovf_reg, ork_reg, oid_reg};
    assign m_tuser   = okind_reg;
    assign m_tlast   = olast_reg;
    assign mem_raddr = ((state_reg == ST_SHIFT_RD) || (state_reg == ST_SHIFT_WR))
                       ? jm1[ADDR_W-1:0] : cur_idx;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        prank_next     = prank_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        emit_cnt_next  = emit_cnt_reg;
        mark_next      = mark_reg;
        first_next     = first_reg;
        prev_rank_next = prev_rank_reg;
        prev_idx_next  = prev_idx_reg;
        best_vld_next  = best_vld_reg;
        best_rank_next = best_rank_reg;
        best_id_next   = best_id_reg;
        best_idx_next  = best_idx_reg;
        pkind_next     = pkind_reg;
        pid_next       = pid_reg;
        prk_next       = prk_reg;
        povf_next      = povf_reg;
        plast_next     = plast_reg;
        pmore_next     = pmore_reg;
        ovld_next      = ovld_reg && !m_tready;
        okind_next     = okind_reg;
        oid_next       = oid_reg;
        ork_next       = ork_reg;
        oovf_next      = oovf_reg;
        olast_next     = olast_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_idx;
        mem_wdata      = {sum_sat, key_reg};

        case (state_reg)
            ST_IDLE:
            begin
                // default pending word is a plain acknowledge
                pkind_next = KIND_ACK;
                pid_next   = '0;
                prk_next   = '0;
                povf_next  = 1'b0;
                plast_next = 1'b1;
                pmore_next = 1'b0;
                if (s_tvalid)
                begin
                    act_next   = s_tuser;
                    key_next   = s_tdata[ID_W-1:0];
                    prank_next = s_tdata[ID_W+PRANK_W-1:ID_W];
                    idx_next   = '0;
                    n_next     = '0;
                    case (s_tuser)
                        ACT_ADD, ACT_INTERSECT:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        ACT_COMMIT:
                        begin
                            state_next = ST_CMT_RD;
                        end
                        ACT_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                pkind_next = KIND_EMPTY;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                first_next    = 1'b1;
                                emit_cnt_next = '0;
                                best_vld_next = 1'b0;
                                state_next    = ST_SORT_RD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            mark_next  = '0;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // ordered search for the first id not below the key
            ST_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN_EV;
                end
            end

            ST_SCAN_EV:
            begin
                if (rd_id < key_reg)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
                else if (rd_id == key_reg)
                begin
                    mem_we = 1'b1;
                    if (act_reg == ACT_INTERSECT)
                    begin
                        mark_next[cur_idx] = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            // no match at place idx
            ST_DECIDE:
            begin
                if (act_reg != ACT_ADD)
                begin
                    state_next = ST_EMIT;
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    povf_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end

            // move the tail up by one, top first
            ST_SHIFT_RD:
            begin
                if (j_reg == idx_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {{(RANK_W-PRANK_W){1'b0}}, prank_reg, key_reg};
                    mark_next[cur_idx] = 1'b0;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
                mark_next[j_reg[ADDR_W-1:0]] = mark_reg[jm1[ADDR_W-1:0]];
                j_next     = jm1;
                state_next = ST_SHIFT_RD;
            end

            // compaction of marked entries
            ST_CMT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = n_reg;
                    mark_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CMT_EV;
                end
            end

            ST_CMT_EV:
            begin
                if (mark_reg[cur_idx])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = n_reg[ADDR_W-1:0];
                    mem_wdata = rdata_reg;
                    n_next    = n_reg + CNT_W'(1);
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_CMT_RD;
            end

            // one selection pass: next entry after the previous one in rank order
            ST_SORT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pkind_next     = KIND_ENTRY;
                    pid_next       = best_id_reg;
                    prk_next       = best_rank_reg;
                    plast_next     = (emit_cnt_reg + CNT_W'(1)) == count_reg;
                    pmore_next     = (emit_cnt_reg + CNT_W'(1)) != count_reg;
                    emit_cnt_next  = emit_cnt_reg + CNT_W'(1);
                    first_next     = 1'b0;
                    prev_rank_next = best_rank_reg;
                    prev_idx_next  = best_idx_reg;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SORT_EV;
                end
            end

            ST_SORT_EV:
            begin
                if (eligible && better)
                begin
                    best_vld_next  = 1'b1;
                    best_rank_next = rd_rank;
                    best_id_next   = rd_id;
                    best_idx_next  = cur_idx;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_SORT_RD;
            end

            // hand the pending word to the output register
            ST_EMIT:
            begin
                if (!ovld_reg || m_tready)
                begin
                    ovld_next  = 1'b1;
                    okind_next = pkind_reg;
                    oid_next   = pid_reg;
                    ork_next   = prk_reg;
                    oovf_next  = povf_reg;
                    olast_next = plast_reg;
                    if (pmore_reg)
                    begin
                        idx_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = ST_SORT_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mark_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mark_reg  <= mark_next;
            ovld_reg  <= ovld_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        prank_reg     <= prank_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        n_reg         <= n_next;
        emit_cnt_reg  <= emit_cnt_next;
        first_reg     <= first_next;
        prev_rank_reg <= prev_rank_next;
        prev_idx_reg  <= prev_idx_next;
        best_vld_reg  <= best_vld_next;
        best_rank_reg <= best_rank_next;
        best_id_reg   <= best_id_next;
        best_idx_reg  <= best_idx_next;
        pkind_reg     <= pkind_next;
        pid_reg       <= pid_next;
        prk_reg       <= prk_next;
        povf_reg      <= povf_next;
        plast_reg     <= plast_next;
        pmore_reg     <= pmore_next;
        okind_reg     <= okind_next;
        oid_reg       <= oid_next;
        ork_reg       <= ork_next;
        oovf_reg      <= oovf_next;
        olast_reg     <= olast_next;
    end

`ifndef NO_ASSERTIONS
    // entry count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // empty-table word is always the only and last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_EMPTY)) |-> m_tlast)
        else $error("empty word without last");

    // overflow only rides on an acknowledge
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[64]) |-> ((m_tuser == KIND_ACK) && m_tlast))
        else $error("overflow on a non-acknowledge word");

    // a read-out pass never finishes without a selected entry
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SORT_RD) && (idx_reg == count_reg)) |-> best_vld_reg)
        else $error("selection pass found no entry");
`endif

endmodule

`default_nettype wire
